// File: rtl/aprd_pkg.sv
// Shared constants, register indexes and control structs of the peak/RMS level meter.
package aprd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int FILL_W     = 13;
    localparam int SUM_W      = 43;
    localparam int FS_W       = 15;
    localparam int LEVEL_W    = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int MAX_WINDOW_DEF = 4096;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_RMS_MODE   = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE = 2'd2;

    // Window snapshot handed to the level unit
    typedef struct packed {
        logic              start;
        logic              rms;
        logic [MAG_W-1:0]  peak;
        logic [SUM_W-1:0]  sum;
        logic [FILL_W-1:0] count;
        logic [FS_W-1:0]   fs;
    } lvl_req_t;

    // Result of the level unit, held until acknowledged
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } lvl_rsp_t;

endpackage

// File: rtl/aprd_stream_if.sv
// Valid/ready channel interfaces for samples in and levels out.
interface aprd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        end_of_clip;

    modport source (output valid, output sample, output end_of_clip, input ready);
    modport sink   (input valid, input sample, input end_of_clip, output ready);
endinterface

interface aprd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] level;
    logic        last_level;

    modport source (output valid, output level, output last_level, input ready);
    modport sink   (input valid, input level, input last_level, output ready);
endinterface

// File: rtl/aprd_level_unit.sv
// Iterative level unit: shared restoring divider, followed in RMS mode by a digit-by-digit square root.
module aprd_level_unit
    import aprd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lvl_req_t req,
    input  logic     ack,
    output lvl_rsp_t rsp
);

    localparam logic [4:0] DIV_LAST_RMS  = 5'd31;
    localparam logic [4:0] DIV_LAST_PEAK = 5'd15;
    localparam logic [4:0] SQRT_LAST     = 5'd15;

    typedef enum logic [2:0] {
        LU_IDLE,
        LU_MUL_A,
        LU_MUL_B,
        LU_CHECK,
        LU_DIV,
        LU_SQRT,
        LU_DONE
    } lu_state_t;

    lu_state_t          state_reg;
    logic               rms_reg;
    logic [FILL_W-1:0]  count_reg;
    logic [FS_W-1:0]    fs_reg;
    logic [2*FS_W-1:0]  sqfs_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [31:0]        quo_reg;
    logic [31:0]        res_reg;
    logic [31:0]        bit_reg;
    logic [4:0]         step_reg;
    logic [LEVEL_W-1:0] level_reg;

    logic [FS_W-1:0]   fs_eff;
    logic [2*FS_W-1:0] mul_a;
    logic [SUM_W-1:0]  mul_b;
    logic [SUM_W:0]    rem_sh;
    logic [SUM_W:0]    div_diff;
    logic              div_ge;
    logic [SUM_W-1:0]  rem_step;
    logic [32:0]       sq_trial;
    logic              sq_ge;
    logic [31:0]       sq_x;
    logic [31:0]       res_step;

    assign fs_eff = (req.fs == '0) ? FS_W'(1) : req.fs;
    assign mul_a  = fs_reg * fs_reg;
    assign mul_b  = sqfs_reg * count_reg;

    // One restoring division step
    assign rem_sh   = {rem_reg, 1'b0};
    assign div_diff = rem_sh - {1'b0, den_reg};
    assign div_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_step = div_ge ? div_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];

    // One square-root digit; quo_reg holds the shrinking radicand
    assign sq_trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq_ge    = {1'b0, quo_reg} >= sq_trial;
    assign sq_x     = quo_reg - sq_trial[31:0];
    assign res_step = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= LU_IDLE;
        end
        else begin
            case (state_reg)
                LU_IDLE:
                begin
                    if (req.start) begin
                        rms_reg   <= req.rms;
                        count_reg <= req.count;
                        fs_reg    <= fs_eff;
                        den_reg   <= SUM_W'(fs_eff);
                        rem_reg   <= req.rms ? req.sum : SUM_W'(req.peak);
                        state_reg <= req.rms ? LU_MUL_A : LU_CHECK;
                    end
                end
                LU_MUL_A:
                begin
                    sqfs_reg  <= mul_a;
                    state_reg <= LU_MUL_B;
                end
                LU_MUL_B:
                begin
                    den_reg   <= (mul_b == '0) ? SUM_W'(1) : mul_b;
                    state_reg <= LU_CHECK;
                end
                LU_CHECK:
                begin
                    // ratio of one or more saturates
                    if (rem_reg >= den_reg) begin
                        level_reg <= '1;
                        state_reg <= LU_DONE;
                    end
                    else begin
                        quo_reg   <= '0;
                        step_reg  <= rms_reg ? DIV_LAST_RMS : DIV_LAST_PEAK;
                        state_reg <= LU_DIV;
                    end
                end
                LU_DIV:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= {quo_reg[30:0], div_ge};
                    if (step_reg == '0) begin
                        if (rms_reg) begin
                            res_reg   <= '0;
                            bit_reg   <= 32'h4000_0000;
                            step_reg  <= SQRT_LAST;
                            state_reg <= LU_SQRT;
                        end
                        else begin
                            level_reg <= {quo_reg[14:0], div_ge};
                            state_reg <= LU_DONE;
                        end
                    end
                    else begin
                        step_reg <= step_reg - 5'd1;
                    end
                end
                LU_SQRT:
                begin
                    if (sq_ge) begin
                        quo_reg <= sq_x;
                    end
                    res_reg  <= res_step;
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == '0) begin
                        level_reg <= res_step[LEVEL_W-1:0];
                        state_reg <= LU_DONE;
                    end
                end
                LU_DONE:
                begin
                    if (ack) begin
                        state_reg <= LU_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= LU_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = (state_reg == LU_DONE);
    assign rsp.level = level_reg;

endmodule

// File: rtl/audio_peak_rms_decimator_unit.sv
// Top level of the windowed peak/RMS audio level meter with APB configuration.
//
//  channel   | dir | transfer when          | payload
//  ----------+-----+------------------------+---------------------------------
//  samples   | in  | valid && ready         | sample (s16), end_of_clip
//  levels    | out | valid && ready         | level (u16 Q0.16), last_level
//  apb       | in  | psel&penable&pwrite    | window_len, rms_mode, full_scale
//
//  A sample that does not close a window passes through capture and accumulate.
//  A closing sample then runs a 16-step divide in peak mode and, in RMS mode,
//  two multiplies, a 32-step divide and a 16-step square root; a saturated level
//  skips the divide and root. All of it runs in the single shared divide/root
//  unit. samples.ready is low meanwhile.
//  A finished level waits in the output register; the next sample is taken
//  while it waits, and only the next window end stalls on it.
//  Reset clears the accumulators, the handshakes and restores register defaults.
module audio_peak_rms_decimator_unit
    import aprd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    aprd_in_if.sink               samples,
    aprd_out_if.source            levels
);

    // Longest window the fill counter can reach
    localparam int FILL_MAX  = (1 << FILL_W) - 1;
    localparam int WIN_CLAMP = (MAX_WINDOW > FILL_MAX) ? FILL_MAX : MAX_WINDOW;
    localparam logic [FILL_W-1:0] WIN_CLAMP_V = FILL_W'(WIN_CLAMP);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_LVL
    } top_state_t;

    top_state_t         state_reg;
    logic [FILL_W-1:0]  window_len_reg;
    logic               rms_mode_reg;
    logic [FS_W-1:0]    full_scale_reg;

    logic [MAG_W-1:0]   mag_reg;
    logic               last_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [MAG_W-1:0]   peak_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_last_reg;

    logic               cfg_wr;
    logic               in_xfer;
    logic               out_xfer;
    logic [MAG_W-1:0]   s_ext;
    logic [MAG_W-1:0]   mag_in;
    logic [2*MAG_W-1:0] sq;
    logic [SUM_W-1:0]   sum_next;
    logic [MAG_W-1:0]   peak_next;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  len_eff;
    logic               win_end;
    logic               slot_free;
    logic               lu_ack;
    lvl_req_t           lu_req;
    lvl_rsp_t           lu_rsp;

    // ------------------------------------------------------------------
    // APB register file: writes complete in the access phase, no wait states
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            window_len_reg <= FILL_W'(1);
            rms_mode_reg   <= 1'b0;
            full_scale_reg <= FS_W'(1);
        end
        else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WINDOW_LEN: window_len_reg <= pwdata[FILL_W-1:0];
                REG_RMS_MODE:   rms_mode_reg   <= pwdata[0];
                REG_FULL_SCALE: full_scale_reg <= pwdata[FS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW_LEN: prdata = APB_DATA_W'(window_len_reg);
            REG_RMS_MODE:   prdata = APB_DATA_W'(rms_mode_reg);
            REG_FULL_SCALE: prdata = APB_DATA_W'(full_scale_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sample capture: magnitude of a two's-complement sample, -32768 -> 32768
    // ------------------------------------------------------------------
    assign samples.ready = (state_reg == ST_IDLE);
    assign in_xfer       = samples.valid && samples.ready;
    assign s_ext         = {samples.sample[SAMPLE_W-1], samples.sample};
    assign mag_in        = samples.sample[SAMPLE_W-1] ? (MAG_W'(0) - s_ext) : s_ext;

    // ------------------------------------------------------------------
    // Window accumulation
    // ------------------------------------------------------------------
    assign sq        = mag_reg * mag_reg;
    assign sum_next  = sum_reg + SUM_W'(sq);
    assign peak_next = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign fill_next = fill_reg + FILL_W'(1);

    // Effective length: zero acts as one, clamp to the longest window
    always_comb begin
        if (window_len_reg == '0) begin
            len_eff = FILL_W'(1);
        end
        else if (window_len_reg > WIN_CLAMP_V) begin
            len_eff = WIN_CLAMP_V;
        end
        else begin
            len_eff = window_len_reg;
        end
    end

    assign win_end = (fill_next >= len_eff) || last_reg;

    // Hand the closing window to the level unit in the accumulate cycle
    assign lu_req.start = (state_reg == ST_ACC) && win_end;
    assign lu_req.rms   = rms_mode_reg;
    assign lu_req.peak  = peak_next;
    assign lu_req.sum   = sum_next;
    assign lu_req.count = fill_next;
    assign lu_req.fs    = full_scale_reg;

    // Drain the level unit only once the output register can take it
    assign out_xfer  = levels.valid && levels.ready;
    assign slot_free = !out_valid_reg || levels.ready;
    assign lu_ack    = (state_reg == ST_LVL) && lu_rsp.done && slot_free;

    aprd_level_unit u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lu_req),
        .ack   (lu_ack),
        .rsp   (lu_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer: state, accumulators and the output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            peak_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            // Drop the sent level unless a new one replaces it in the same cycle
            if (out_xfer && !lu_ack) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer) begin
                        mag_reg   <= mag_in;
                        last_reg  <= samples.end_of_clip;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    if (win_end) begin
                        // window closes: clear and wait for the level
                        fill_reg  <= '0;
                        peak_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_LVL;
                    end
                    else begin
                        fill_reg  <= fill_next;
                        peak_reg  <= peak_next;
                        sum_reg   <= sum_next;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LVL:
                begin
                    if (lu_ack) begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= lu_rsp.level;
                        out_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign levels.valid      = out_valid_reg;
    assign levels.level      = out_level_reg;
    assign levels.last_level = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LVL && lu_rsp.done))
        else $error("output loaded without a finished level");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LVL) |-> (fill_reg == '0 && peak_reg == '0 && sum_reg == '0))
        else $error("accumulators not cleared while a level is computed");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < WIN_CLAMP_V)
        else $error("fill count reached the longest window without closing");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        lu_req.start |-> !lu_rsp.done)
        else $error("level unit started while holding a result");

endmodule

// File: bench/audio_peak_rms_decimator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed peak/RMS audio level meter.
module audio_peak_rms_decimator_unit_test;
    import aprd_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    // Longer than the slowest level computation (RMS divide plus square root).
    localparam int QUIET_CYCLES = 100;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int WINDOW_CAP   = 4096;
    localparam int PHASE_ITEMS  = 330;
    localparam int LONG_ITEMS   = 200;
    localparam int WIDE_WINDOW  = 128;

    // One expected level transfer
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last_level;
    } level_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    aprd_in_if  samples_if ();
    aprd_out_if levels_if ();

    audio_peak_rms_decimator_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_if),
        .levels  (levels_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copies of the configuration registers, updated on every APB write
    logic [FILL_W-1:0] cfg_window_len;
    logic              cfg_rms_mode;
    logic [FS_W-1:0]   cfg_full_scale;

    // Predicted window accumulators
    logic [FILL_W-1:0] acc_fill;
    logic [MAG_W-1:0]  acc_peak;
    logic [SUM_W-1:0]  acc_sum;

    // Levels the block owes us, oldest first
    level_t expected_levels[$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Effective window length: zero acts as one, anything past the cap acts as the cap.
    function automatic int eff_window(input logic [FILL_W-1:0] len);
        if (len == '0)
            return 1;
        if (len > WINDOW_CAP)
            return WINDOW_CAP;
        return int'(len);
    endfunction

    // Normalized level of a closed window, Q0.16, truncated and saturated.
    function automatic logic [LEVEL_W-1:0] window_level(input logic              rms,
                                                        input logic [FS_W-1:0]   fs,
                                                        input logic [MAG_W-1:0]  peak,
                                                        input logic [SUM_W-1:0]  sum,
                                                        input logic [FILL_W-1:0] count);
        bit [15:0] fs_eff;
        bit [32:0] ratio;
        bit [63:0] den;
        bit [79:0] num;
        bit [31:0] quo;
        bit [16:0] root;
        bit [16:0] trial;
        fs_eff = (fs == '0) ? 16'd1 : {1'b0, fs};
        if (!rms) begin
            ratio = {peak, 16'h0} / fs_eff;
            return (ratio >= 33'h10000) ? 16'hFFFF : ratio[15:0];
        end
        // Mean square over full scale squared, as a 32-bit fraction, then its root
        den = 64'(count) * 64'(fs_eff) * 64'(fs_eff);
        if (den == 0)
            den = 1;
        if (64'(sum) >= den)
            return 16'hFFFF;
        num = 80'(sum) << 32;
        quo = 32'(num / 80'(den));
        root = '0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (17'd1 << b);
            if (64'(trial) * 64'(trial) <= 64'(quo))
                root = trial;
        end
        return root[15:0];
    endfunction

    // Advance the predicted window by one accepted sample; queue a level if it closes.
    function automatic void predict_sample(input logic [15:0] sample, input logic eoc);
        logic [MAG_W-1:0] mag;
        level_t           lv;
        // -32768 has magnitude 32768, hence the extra bit
        mag = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
        acc_fill = acc_fill + 1'b1;
        if (mag > acc_peak)
            acc_peak = mag;
        acc_sum = acc_sum + SUM_W'(mag) * SUM_W'(mag);
        if (int'(acc_fill) >= eff_window(cfg_window_len) || eoc) begin
            lv.level      = window_level(cfg_rms_mode, cfg_full_scale, acc_peak, acc_sum,
                                         acc_fill);
            lv.last_level = eoc;
            expected_levels.push_back(lv);
            acc_fill = '0;
            acc_peak = '0;
            acc_sum  = '0;
        end
    endfunction

    // Level receiver: stall at random, at the rate of the current phase.
    always @(posedge clk)
        levels_if.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Level checker: compare each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        level_t want;
        if (rst_n === 1'b1 && levels_if.valid === 1'b1 && levels_if.ready === 1'b1) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("level with nothing pending", levels_if.level, 0);
            end else begin
                want = expected_levels.pop_front();
                if (levels_if.level !== want.level)
                    report_mismatch("level", levels_if.level, want.level);
                if (levels_if.last_level !== want.last_level)
                    report_mismatch("last_level", levels_if.last_level, want.last_level);
            end
        end
    end

    // Drive one APB write; psel stays high so transfers may follow back to back.
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_WINDOW_LEN: cfg_window_len = data[FILL_W-1:0];
            REG_RMS_MODE:   cfg_rms_mode   = data[0];
            REG_FULL_SCALE: cfg_full_scale = data[FS_W-1:0];
            default: ;
        endcase
    endtask

    // Drive one APB read and compare the returned register value.
    task automatic apb_read_check(input logic [1:0] idx, input logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold off samples until every owed level is in, then let the block settle.
    task automatic wait_quiet();
        samples_if.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write all three registers with junk in the unused upper bits, then read them back.
    task automatic set_config(input int len, input int rms, input int fs);
        wait_quiet();
        apb_write(REG_WINDOW_LEN, ($urandom() << FILL_W) | len);
        apb_write(REG_RMS_MODE, ($urandom() << 1) | rms);
        apb_write(REG_FULL_SCALE, ($urandom() << FS_W) | fs);
        apb_read_check(REG_WINDOW_LEN, APB_DATA_W'(cfg_window_len));
        apb_read_check(REG_RMS_MODE, APB_DATA_W'(cfg_rms_mode));
        apb_read_check(REG_FULL_SCALE, APB_DATA_W'(cfg_full_scale));
        apb_idle();
    endtask

    // Send one sample transfer after a random gap; predict once it is taken.
    task automatic send_sample(input logic [15:0] sample, input logic eoc);
        while ($urandom_range(99) < send_idle_pct) begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid       <= 1'b1;
        samples_if.sample      <= sample;
        samples_if.end_of_clip <= eoc;
        do @(posedge clk); while (samples_if.ready !== 1'b1);
        predict_sample(sample, eoc);
    endtask

    // Reset values of the registers, and single-sample windows at unit full scale.
    task automatic test_reset_defaults();
        apb_read_check(REG_WINDOW_LEN, 32'd1);
        apb_read_check(REG_RMS_MODE, 32'd0);
        apb_read_check(REG_FULL_SCALE, 32'd1);
        apb_idle();
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
    endtask

    // Peak mode: saturation, the most negative sample, partial windows, zero full scale.
    task automatic test_peak_levels();
        set_config(4, 0, 32767);
        send_sample(16'd16384, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd3, 1'b1);
        set_config(2, 0, 0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b1);
    endtask

    // RMS mode: full-scale extremes, clip end on the first sample, zero length and scale.
    task automatic test_rms_levels();
        set_config(3, 1, 32767);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'd12345, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1, 1'b1);
        send_sample(16'h8000, 1'b1);
        set_config(0, 1, 0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'hFFFF, 1'b1);
    endtask

    // Register changes with a window half full: shrink below the fill, then grow.
    task automatic test_midwindow_change();
        set_config(8, 0, 1000);
        repeat (5) send_sample(16'($urandom_range(2000) - 1000), 1'b0);
        set_config(3, 1, 20000);
        send_sample(16'd7000, 1'b0);
        send_sample(16'hC000, 1'b0);
        send_sample(16'd99, 1'b0);
        set_config(16, 0, 500);
        repeat (3) send_sample(16'($urandom_range(1000) - 500), 1'b0);
        send_sample(16'd250, 1'b1);
    endtask

    // Well-formed clips with random content under random settings, plus unfinished clips.
    task automatic test_random_clips(input int item_count);
        int          sent;
        int          clip_len;
        int          style;
        int          len;
        int          fs;
        bit          unfinished;
        logic [15:0] s;
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(1) == 0) begin
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = 1;
                    2, 3, 4, 5: len = $urandom_range(8, 2);
                    6, 7:    len = $urandom_range(40, 9);
                    default: len = $urandom_range(200, 41);
                endcase
                case ($urandom_range(9))
                    0:       fs = 0;
                    1:       fs = 1;
                    2:       fs = 32767;
                    3, 4, 5: fs = $urandom_range(32767, 1);
                    6, 7:    fs = $urandom_range(255, 1);
                    default: fs = $urandom_range(32767, 8000);
                endcase
                set_config(len, $urandom_range(1), fs);
            end
            clip_len = $urandom_range(3 * eff_window(cfg_window_len) + 2, 1);
            if (clip_len > 120)
                clip_len = $urandom_range(120, 1);
            // An unfinished clip leaves a partial window for the next settings to close
            unfinished = ($urandom_range(9) < 2);
            style = $urandom_range(3);
            for (int i = 0; i < clip_len; i++)
            begin
                case ((style == 3) ? $urandom_range(2) : style)
                    0: s = 16'($urandom());
                    1: s = 16'($urandom_range(600) - 300);
                    default:
                        case ($urandom_range(5))
                            0:       s = 16'h8000;
                            1:       s = 16'h7FFF;
                            2:       s = 16'h0000;
                            3:       s = 16'hFFFF;
                            4:       s = 16'h0001;
                            default: s = 16'h8001;
                        endcase
                endcase
                send_sample(s, (i == clip_len - 1) && !unfinished);
            end
            sent += clip_len;
        end
    endtask

    // Long windows: the largest length setting closed by the clip end, then a wide peak window.
    task automatic test_long_windows();
        set_config(8191, 1, 32767);
        for (int i = 0; i < LONG_ITEMS - 1; i++)
        begin
            case (i % 3)
                0:       send_sample(16'h8000, 1'b0);
                1:       send_sample(16'h7FFF, 1'b0);
                default: send_sample(16'($urandom()), 1'b0);
            endcase
        end
        send_sample(16'h8000, 1'b1);
        set_config(WIDE_WINDOW, 0, 32767);
        for (int i = 0; i < WIDE_WINDOW; i++)
            send_sample(16'($urandom_range(8000) - 4000), 1'b0);
    endtask

    initial begin
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        samples_if.valid       <= 1'b0;
        samples_if.sample      <= '0;
        samples_if.end_of_clip <= 1'b0;
        cfg_window_len = 13'd1;
        cfg_rms_mode   = 1'b0;
        cfg_full_scale = 15'd1;
        acc_fill = '0;
        acc_peak = '0;
        acc_sum  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalled
        send_idle_pct  = 25;
        sink_stall_pct = 85;
        test_reset_defaults();
        test_peak_levels();
        test_rms_levels();
        test_midwindow_change();
        test_random_clips(PHASE_ITEMS);

        // Swap the pressure: sparse samples, eager receiver
        send_idle_pct  = 85;
        sink_stall_pct = 25;
        test_random_clips(PHASE_ITEMS);

        // Full rate on both sides
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        test_random_clips(PHASE_ITEMS);
        test_long_windows();

        // Drain what is owed, bounded, then give the block time to settle
        samples_if.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_levels.size() != 0; n++)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch("levels never delivered", 0, expected_levels.size());

        if (error_count == 0)
            $display("** audio_peak_rms_decimator_unit: PASSED **");
        else
            $display("** audio_peak_rms_decimator_unit: FAILED **");
        $finish;
    end

    // Watchdog: the slowest correct run ends well inside this.
    initial begin
        #20_000_000;
        $display("** audio_peak_rms_decimator_unit: FAILED **");
        $finish;
    end

endmodule
